// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock edge, disabled in reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hw/rtl/fcla_pkg.sv
// Package for the free chunk list allocator: constants, codes, control structs.
// No dependencies.
`timescale 1ns / 1ps
package fcla_pkg;
  localparam int unsigned ListDepthDefault   = 64;
  localparam int unsigned HeaderBytesDefault = 8;
  localparam logic [31:0] SplitReset         = 32'd102400;
  localparam int unsigned PaddrW             = 2;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_SPLIT  = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  localparam logic [PaddrW-1:0] RegSplitThr = 2'd0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ARD,     // alloc: issue read at scan index
    S_ACHK,    // alloc: check entry
    S_RMRD,    // remove: read k+1
    S_RMWR,    // remove: write k
    S_FRD,     // free: issue read at scan index
    S_FCHK,    // free: compare offset
    S_SHRD,    // shift: read k-1
    S_SHWR,    // shift: write k
    S_INS,     // write new entry, read next
    S_NCHK,    // check next adjacency
    S_PRD,     // read prev
    S_PCHK,    // check prev adjacency
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;       // capture request
    logic idx_clr;
    logic idx_inc;
    logic idx_dec;
    logic k_from_idx; // k = idx
    logic k_from_idxp1; // k = idx + 1
    logic k_from_cnt; // k = count
    logic k_inc;
    logic k_dec;
    logic rd_idx;     // read address idx
    logic rd_kp1;
    logic rd_km1;
    logic rd_idxp1;
    logic rd_idxm1;
    logic wr_k_hold;  // write read data to k
    logic wr_split;   // write split entry at idx
    logic wr_new;     // write new entry at idx
    logic wr_nmerge;  // write next-merged entry at idx
    logic wr_pmerge;  // write prev-merged entry at idx-1
    logic cnt_inc;
    logic cnt_dec;
    logic res_hit;
    logic res_split;
    logic res_miss;
    logic res_full;
    logic res_zero;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic idx_lt_cnt;
    logic idx_gt0;
    logic idxp1_lt_cnt;
    logic k_gt_idx;
    logic kp1_lt_cnt;
    logic full;
    logic fits;
    logic can_split;
    logic off_gt;
    logic next_adj;
    logic prev_adj;
    logic out_busy;
  } stat_t;
endpackage

// File: hw/rtl/fcla_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on nothing.
`timescale 1ns / 1ps
interface fcla_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] request_size;
  logic [31:0] free_offset;
  modport source (output valid, cmd, request_size, free_offset, input ready);
  modport sink (input valid, cmd, request_size, free_offset, output ready);
endinterface

interface fcla_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] chunk_offset;
  logic [31:0] chunk_size;
  modport source (output valid, status, chunk_offset, chunk_size, input ready);
  modport sink (input valid, status, chunk_offset, chunk_size, output ready);
endinterface

// File: hw/rtl/fcla_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module fcla_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// File: hw/rtl/fcla_datapath.sv
// Datapath: request registers, indexes, list memory, compares, result register.
// Depends on fcla_pkg and fcla_ram.
`timescale 1ns / 1ps
module fcla_datapath #(
  parameter int unsigned ListDepth   = 64,
  parameter int unsigned HeaderBytes = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fcla_pkg::ctrl_t       ctrl_i,
  output fcla_pkg::stat_t       stat_o,
  input  logic [1:0]            cmd_i,
  input  logic [31:0]           request_size_i,
  input  logic [31:0]           free_offset_i,
  input  logic [31:0]           split_thr_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [1:0]            status_o,
  output logic [31:0]           chunk_offset_o,
  output logic [31:0]           chunk_size_o
);
  import fcla_pkg::*;
  localparam int unsigned AW = $clog2(ListDepth);
  localparam int unsigned CW = $clog2(ListDepth + 1);
  localparam logic [32:0] Hdr = 33'(HeaderBytes);

  logic [1:0]  cmd_q;
  logic [31:0] req_q, foff_q;
  logic [CW-1:0] idx_q, k_q, cnt_q;
  logic [63:0] rdata;
  logic [31:0] cur_q;
  logic [1:0]  st_q;
  logic [31:0] ro_q, rs_q;

  logic [31:0] r_off, r_size, surplus;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0] wdata;
  logic [CW-1:0] rsel;

  assign r_off  = rdata[63:32];
  assign r_size = rdata[31:0];
  assign surplus = r_size - req_q;

  fcla_ram #(.Width(64), .Depth(ListDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  always_comb begin
    rsel = idx_q;
    if (ctrl_i.rd_kp1) rsel = k_q + CW'(1);
    if (ctrl_i.rd_km1) rsel = k_q - CW'(1);
    if (ctrl_i.rd_idxp1) rsel = idx_q + CW'(1);
    if (ctrl_i.rd_idxm1) rsel = idx_q - CW'(1);
    raddr = rsel[AW-1:0];
  end

  always_comb begin
    we = 1'b0;
    waddr = k_q[AW-1:0];
    wdata = rdata;
    if (ctrl_i.wr_k_hold) we = 1'b1;
    if (ctrl_i.wr_split) begin
      we = 1'b1;
      waddr = idx_q[AW-1:0];
      wdata = {r_off + req_q + Hdr[31:0], r_size - req_q - Hdr[31:0]};
    end
    if (ctrl_i.wr_new) begin
      we = 1'b1;
      waddr = idx_q[AW-1:0];
      wdata = {foff_q, req_q};
    end
    if (ctrl_i.wr_nmerge) begin
      we = 1'b1;
      waddr = idx_q[AW-1:0];
      wdata = {foff_q, cur_q + Hdr[31:0] + r_size};
    end
    if (ctrl_i.wr_pmerge) begin
      we = 1'b1;
      waddr = idx_q[AW-1:0] - AW'(1);
      wdata = {r_off, r_size + Hdr[31:0] + cur_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= cmd_i;
      req_q  <= request_size_i;
      foff_q <= free_offset_i;
      cur_q  <= request_size_i;
    end
    if (ctrl_i.wr_nmerge) cur_q <= cur_q + Hdr[31:0] + r_size;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      k_q   <= '0;
      cnt_q <= '0;
    end else begin
      if (ctrl_i.idx_clr) idx_q <= '0;
      else if (ctrl_i.idx_inc) idx_q <= idx_q + CW'(1);
      else if (ctrl_i.idx_dec) idx_q <= idx_q - CW'(1);
      if (ctrl_i.k_from_idx) k_q <= idx_q;
      else if (ctrl_i.k_from_idxp1) k_q <= idx_q + CW'(1);
      else if (ctrl_i.k_from_cnt) k_q <= cnt_q;
      else if (ctrl_i.k_inc) k_q <= k_q + CW'(1);
      else if (ctrl_i.k_dec) k_q <= k_q - CW'(1);
      if (ctrl_i.cnt_inc) cnt_q <= cnt_q + CW'(1);
      else if (ctrl_i.cnt_dec) cnt_q <= cnt_q - CW'(1);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (ctrl_i.out_load) out_valid_o <= 1'b1;
    else if (out_ready_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.res_hit) begin
      ro_q <= r_off;
      rs_q <= ctrl_i.res_split ? req_q : r_size;
      st_q <= ST_OK;
    end
    if (ctrl_i.res_miss) begin
      ro_q <= '0; rs_q <= '0; st_q <= ST_MISS;
    end
    if (ctrl_i.res_full) begin
      ro_q <= '0; rs_q <= '0; st_q <= ST_FULL;
    end
    if (ctrl_i.res_zero) begin
      ro_q <= '0; rs_q <= '0; st_q <= ST_OK;
    end
  end
  assign status_o = st_q;
  assign chunk_offset_o = ro_q;
  assign chunk_size_o = rs_q;

  always_comb begin
    stat_o.idx_lt_cnt   = idx_q < cnt_q;
    stat_o.idx_gt0      = idx_q != '0;
    stat_o.idxp1_lt_cnt = (idx_q + CW'(1)) < cnt_q;
    stat_o.k_gt_idx     = k_q > idx_q;
    stat_o.kp1_lt_cnt   = (k_q + CW'(1)) < cnt_q;
    stat_o.full         = cnt_q >= CW'(ListDepth);
    stat_o.fits         = r_size >= req_q;
    stat_o.can_split    = (cmd_q == CMD_SPLIT) && (surplus >= split_thr_i)
                          && (surplus >= Hdr[31:0]);
    stat_o.off_gt       = r_off > foff_q;
    stat_o.next_adj     = ({1'b0, foff_q} + {1'b0, cur_q} + Hdr) == {1'b0, r_off};
    stat_o.prev_adj     = ({1'b0, r_off} + {1'b0, r_size} + Hdr) == {1'b0, foff_q};
    stat_o.out_busy     = out_valid_o;
  end
endmodule

// File: hw/rtl/fcla_ctrl.sv
// Controller state machine sequencing scans, shifts and merges over the list.
// Depends on fcla_pkg.
`timescale 1ns / 1ps
module fcla_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      cmd_i,
  output logic            in_ready_o,
  input  fcla_pkg::stat_t stat_i,
  output fcla_pkg::ctrl_t ctrl_o,
  output logic            busy_o
);
  import fcla_pkg::*;
  state_e state_q, state_d;
  cmd_e   cmd;
  logic   go;
  logic   nmrg_q, nmrg_d;
  logic   next_merge, prev_merge;

  assign cmd = cmd_e'(cmd_i);
  assign in_ready_o = (state_q == S_IDLE) && !stat_i.out_busy;
  assign go = in_valid_i && in_ready_o;
  assign busy_o = state_q != S_IDLE;
  assign next_merge = stat_i.idxp1_lt_cnt && stat_i.next_adj;
  assign prev_merge = stat_i.idx_gt0 && stat_i.prev_adj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      nmrg_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      nmrg_q  <= nmrg_d;
    end
  end

  // nmrg: removal of the merged next entry is running, prev check follows
  always_comb begin
    state_d = state_q;
    nmrg_d = nmrg_q;
    unique case (state_q)
      S_IDLE: begin
        nmrg_d = 1'b0;
        if (go) begin
          unique case (cmd)
            CMD_ALLOC, CMD_SPLIT: state_d = S_ARD;
            CMD_FREE:             state_d = stat_i.full ? S_DONE : S_FRD;
            default:              state_d = S_DONE;
          endcase
        end
      end
      S_ARD:  state_d = stat_i.idx_lt_cnt ? S_ACHK : S_DONE;
      S_ACHK: begin
        if (!stat_i.fits) state_d = S_ARD;
        else if (stat_i.can_split) state_d = S_DONE;
        else state_d = S_RMRD;
      end
      S_RMRD: begin
        if (stat_i.kp1_lt_cnt) state_d = S_RMWR;
        else if (nmrg_q) state_d = S_PRD;
        else state_d = S_DONE;
      end
      S_RMWR: state_d = S_RMRD;
      S_FRD:  state_d = stat_i.idx_lt_cnt ? S_FCHK : S_SHRD;
      S_FCHK: state_d = stat_i.off_gt ? S_SHRD : S_FRD;
      S_SHRD: state_d = stat_i.k_gt_idx ? S_SHWR : S_INS;
      S_SHWR: state_d = S_SHRD;
      S_INS:  state_d = S_NCHK;
      S_NCHK: begin
        if (next_merge) begin
          state_d = S_RMRD;
          nmrg_d = 1'b1;
        end else begin
          state_d = S_PRD;
        end
      end
      S_PRD: begin
        state_d = S_PCHK;
        nmrg_d = 1'b0;
      end
      S_PCHK: state_d = prev_merge ? S_RMRD : S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      S_IDLE: if (go) begin
        ctrl_o.load = 1'b1;
        ctrl_o.idx_clr = 1'b1;
        if (cmd == CMD_FREE && stat_i.full) begin
          ctrl_o.res_full = 1'b1;
        end else if (cmd == CMD_UNUSED || cmd == CMD_FREE) begin
          ctrl_o.res_zero = 1'b1;
        end
      end
      S_ARD: begin
        ctrl_o.rd_idx = 1'b1;
        if (!stat_i.idx_lt_cnt) ctrl_o.res_miss = 1'b1;
      end
      S_ACHK: begin
        if (!stat_i.fits) ctrl_o.idx_inc = 1'b1;
        else begin
          ctrl_o.res_hit = 1'b1;
          ctrl_o.res_split = stat_i.can_split;
          if (stat_i.can_split) ctrl_o.wr_split = 1'b1;
          else ctrl_o.k_from_idx = 1'b1;
        end
      end
      S_RMRD: begin
        ctrl_o.rd_kp1 = 1'b1;
        if (!stat_i.kp1_lt_cnt) ctrl_o.cnt_dec = 1'b1;
      end
      S_RMWR: begin
        ctrl_o.wr_k_hold = 1'b1;
        ctrl_o.k_inc = 1'b1;
      end
      S_FRD: begin
        ctrl_o.rd_idx = 1'b1;
        if (!stat_i.idx_lt_cnt) ctrl_o.k_from_cnt = 1'b1;
      end
      S_FCHK: begin
        if (stat_i.off_gt) ctrl_o.k_from_cnt = 1'b1;
        else ctrl_o.idx_inc = 1'b1;
      end
      S_SHRD: ctrl_o.rd_km1 = 1'b1;
      S_SHWR: begin
        ctrl_o.wr_k_hold = 1'b1;
        ctrl_o.k_dec = 1'b1;
      end
      S_INS: begin
        ctrl_o.wr_new = 1'b1;
        ctrl_o.cnt_inc = 1'b1;
        ctrl_o.rd_idxp1 = 1'b1;
      end
      S_NCHK: begin
        if (next_merge) begin
          ctrl_o.wr_nmerge = 1'b1;
          ctrl_o.k_from_idxp1 = 1'b1;
        end
      end
      S_PRD: ctrl_o.rd_idxm1 = 1'b1;
      S_PCHK: begin
        if (prev_merge) begin
          ctrl_o.wr_pmerge = 1'b1;
          ctrl_o.k_from_idx = 1'b1;
        end
      end
      S_DONE: ctrl_o.out_load = 1'b1;
      default: ;
    endcase
  end
endmodule

// File: hw/rtl/free_chunk_list_allocator_unit.sv
// Free chunk list allocator top level: APB register, channels, controller, datapath.
// Depends on fcla_pkg, fcla_if, fcla_ctrl, fcla_datapath, assert_macros.svh.
// Keeps a list of free chunks sorted by offset and answers each request item with
// exactly one result item. One item is worked on at a time: the next request is
// taken only after the result of the last one has been accepted. Each list step
// per entry is a registered RAM read, then a check or a write. An allocate scans
// up to ListDepth entries and, when a whole chunk goes, shifts the tail down; a
// free scans and shifts the tail up, then may remove a merged next and a merged
// previous entry, each a shift of the tail. split_threshold sits at byte
// address 0 (reset 102400); write it only while no item is in flight.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module free_chunk_list_allocator_unit #(
  parameter int unsigned ListDepth   = fcla_pkg::ListDepthDefault,
  parameter int unsigned HeaderBytes = fcla_pkg::HeaderBytesDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  fcla_req_if.sink                  req,
  fcla_rsp_if.source                rsp,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [fcla_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import fcla_pkg::*;
  logic [31:0] thr_q;
  ctrl_t ctrl;
  stat_t stat;
  logic busy;

  assign pready = 1'b1;
  assign prdata = (paddr == RegSplitThr) ? thr_q : '0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= SplitReset;
    else if (psel && penable && pwrite && paddr == RegSplitThr) thr_q <= pwdata;
  end

  fcla_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(req.valid), .cmd_i(req.cmd),
    .in_ready_o(req.ready), .stat_i(stat), .ctrl_o(ctrl), .busy_o(busy)
  );

  fcla_datapath #(.ListDepth(ListDepth), .HeaderBytes(HeaderBytes)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .cmd_i(req.cmd), .request_size_i(req.request_size), .free_offset_i(req.free_offset),
    .split_thr_i(thr_q), .out_ready_i(rsp.ready), .out_valid_o(rsp.valid),
    .status_o(rsp.status), .chunk_offset_o(rsp.chunk_offset), .chunk_size_o(rsp.chunk_size)
  );

  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, busy, !req.ready)
  `ASSERT_NEXT(a_load_valid, clk_i, rst_ni, ctrl.out_load, rsp.valid)
  `ASSERT_IMPL(a_one_result, clk_i, rst_ni, ctrl.out_load, !rsp.valid)
endmodule
